FILE: design/dsti_pkg.sv
// dsti_pkg: shared constants for the decimal string to integer parser
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package dsti_pkg;

   localparam int CH_BITS       = 8;
   localparam int CONSUMED_BITS = 16;
   localparam int PADDR_BITS    = 3;
   localparam int PDATA_BITS    = 32;

   localparam logic [0:0] REG_SIGNED_MODE = 1'b0;

   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_SIGN   = 2'd1;
   localparam logic [1:0] PH_DIGITS = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   localparam logic [CH_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CH_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CH_BITS-1:0] CHAR_MINUS = 8'h2d;
   localparam logic [CH_BITS-1:0] CHAR_PLUS  = 8'h2b;
   localparam logic [CH_BITS-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CH_BITS-1:0] CHAR_CR    = 8'h0d;
   localparam logic [CH_BITS-1:0] CHAR_SPACE = 8'h20;

   localparam int DECIMAL_BASE = 10;

   typedef logic [1:0] phase_type;

endpackage

`default_nettype wire

FILE: design/dsti_req_if.sv
// dsti_req_if: request channel carrying one string byte and a start mark
// depends on dsti_pkg
`default_nettype none

interface dsti_req_if;
   logic                         valid;
   logic                         ready;
   logic [dsti_pkg::CH_BITS-1:0] ch;
   logic                         start_req;

   modport source (output valid, output ch, output start_req, input ready);
   modport sink (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

FILE: design/dsti_rsp_if.sv
// dsti_rsp_if: result channel carrying the parsed value, range flag and count
// depends on dsti_pkg
`default_nettype none

interface dsti_rsp_if #(
   parameter int VALUE_BITS = 64
);
   logic                               valid;
   logic                               ready;
   logic [VALUE_BITS-1:0]              value;
   logic                               range_error;
   logic [dsti_pkg::CONSUMED_BITS-1:0] consumed;

   modport source (output valid, output value, output range_error, output consumed,
                   input ready);
   modport sink (input valid, input value, input range_error, input consumed,
                 output ready);
endinterface

`default_nettype wire

FILE: design/decimal_string_to_integer.sv
// decimal_string_to_integer: streaming decimal parser, one byte per request
// depends on dsti_pkg, dsti_req_if, dsti_rsp_if
//
// channel   direction  payload                              handshake
// req_ch    in         ch[7:0], start_req                   valid/ready
// rsp_ch    out        value, range_error, consumed[15:0]   valid/ready
// csr_*     in         signed_mode at byte address 0        apb write/read
//
// one byte per cycle sustained while the result channel does not stall; a request is latched
// in the request register, then parsed by the times-ten-plus-digit update against the parse state
// a result is registered once its terminating byte advances out of the request register
// reset clears the parse state and signed_mode; no clearing pass
// a stalled result holds the request stage and the parse state when another result is due
`default_nettype none

module decimal_string_to_integer #(
   parameter int VALUE_BITS = 64,
   parameter int COUNT_BITS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   dsti_req_if.sink                            req_ch,
   dsti_rsp_if.source                          rsp_ch,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire  [dsti_pkg::PADDR_BITS-1:0]     csr_paddr,
   input  wire  [dsti_pkg::PDATA_BITS-1:0]     csr_pwdata,
   output logic [dsti_pkg::PDATA_BITS-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam logic [VALUE_BITS-1:0] VMASK   = {VALUE_BITS{1'b1}};
   localparam logic [VALUE_BITS-1:0] TOP     = {1'b1, {(VALUE_BITS-1){1'b0}}};
   localparam logic [VALUE_BITS-1:0] MUL_LIM = VMASK / dsti_pkg::DECIMAL_BASE;
   localparam int EXT_BITS = (COUNT_BITS > dsti_pkg::CONSUMED_BITS) ?
                             COUNT_BITS : dsti_pkg::CONSUMED_BITS;
   localparam logic [EXT_BITS-1:0] CONS_MAX = EXT_BITS'({dsti_pkg::CONSUMED_BITS{1'b1}});

   // configuration
   logic signed_mode_ff, signed_mode_in;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      signed_mode_in = signed_mode_ff;
      if (csr_write && csr_paddr[2:2] == dsti_pkg::REG_SIGNED_MODE) begin
         signed_mode_in = csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:2] == dsti_pkg::REG_SIGNED_MODE) begin
         csr_prdata[0] = signed_mode_ff;
      end
   end

   // request register
   logic                         s1_valid_ff, s1_valid_in;
   logic [dsti_pkg::CH_BITS-1:0] s1_ch_ff, s1_ch_in;
   logic                         s1_start_ff, s1_start_in;
   logic                         advance;

   // parse state
   dsti_pkg::phase_type     phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic                    ovf_ff, ovf_in;
   logic [COUNT_BITS-1:0]   pos_ff, pos_in;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0]             rsp_value_ff, rsp_value_in;
   logic                              rsp_range_ff, rsp_range_in;
   logic [dsti_pkg::CONSUMED_BITS-1:0] rsp_cons_ff, rsp_cons_in;

   // step logic
   dsti_pkg::phase_type   ph;
   logic                  neg;
   logic [VALUE_BITS-1:0] acc;
   logic                  ovf;
   logic [COUNT_BITS-1:0] pos, pos_bump;
   logic                  is_ws, is_sign, is_digit;
   logic [VALUE_BITS-1:0] times_ten, limit, fin_value;
   logic [VALUE_BITS:0]   sum;
   logic                  emit;
   logic [EXT_BITS-1:0]   pos_ext;

   assign advance     = s1_valid_ff && (!emit || !rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_ch_in    = s1_ch_ff;
      s1_start_in = s1_start_ff;
      if (req_ch.ready) begin
         s1_valid_in = req_ch.valid;
         s1_ch_in    = req_ch.ch;
         s1_start_in = req_ch.start_req;
      end
   end

   always_comb begin
      ph  = s1_start_ff ? dsti_pkg::PH_SKIP : phase_ff;
      neg = s1_start_ff ? 1'b0 : neg_ff;
      acc = s1_start_ff ? '0 : acc_ff;
      ovf = s1_start_ff ? 1'b0 : ovf_ff;
      pos = s1_start_ff ? '0 : pos_ff;

      is_ws    = s1_ch_ff inside {[dsti_pkg::CHAR_TAB:dsti_pkg::CHAR_CR],
                                  dsti_pkg::CHAR_SPACE};
      is_sign  = s1_ch_ff inside {dsti_pkg::CHAR_MINUS, dsti_pkg::CHAR_PLUS};
      is_digit = s1_ch_ff inside {[dsti_pkg::CHAR_ZERO:dsti_pkg::CHAR_NINE]};
      pos_bump = (&pos) ? pos : pos + 1'b1;

      phase_in = ph;
      neg_in   = neg;
      acc_in   = acc;
      ovf_in   = ovf;
      pos_in   = pos;
      emit     = 1'b0;

      limit     = !signed_mode_ff ? VMASK : (neg ? TOP : TOP - 1'b1);
      times_ten = (acc << 3) + (acc << 1);
      sum       = {1'b0, times_ten} + {{(VALUE_BITS-3){1'b0}}, s1_ch_ff[3:0]};

      if (ph == dsti_pkg::PH_DONE) begin
         emit = 1'b0;
      end else if (ph == dsti_pkg::PH_SKIP && is_ws) begin
         pos_in = pos_bump;
      end else if (ph == dsti_pkg::PH_SKIP && is_sign) begin
         neg_in   = s1_ch_ff == dsti_pkg::CHAR_MINUS;
         pos_in   = pos_bump;
         phase_in = dsti_pkg::PH_SIGN;
      end else if (is_digit) begin
         pos_in   = pos_bump;
         phase_in = dsti_pkg::PH_DIGITS;
         if (!ovf) begin
            if (acc > MUL_LIM || sum[VALUE_BITS] || sum[VALUE_BITS-1:0] > limit) begin
               ovf_in = 1'b1;
            end else begin
               acc_in = sum[VALUE_BITS-1:0];
            end
         end
      end else begin
         emit     = 1'b1;
         phase_in = dsti_pkg::PH_DONE;
      end

      if (ovf) begin
         fin_value = limit;
      end else if (neg) begin
         fin_value = '0 - acc;
      end else begin
         fin_value = acc;
      end
      pos_ext = EXT_BITS'(pos);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_range_in = rsp_range_ff;
      rsp_cons_in  = rsp_cons_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
         if (ph == dsti_pkg::PH_DIGITS) begin
            rsp_value_in = fin_value;
            rsp_range_in = ovf;
            rsp_cons_in  = (pos_ext > CONS_MAX) ? {dsti_pkg::CONSUMED_BITS{1'b1}} :
                           pos_ext[dsti_pkg::CONSUMED_BITS-1:0];
         end else begin
            rsp_value_in = '0;
            rsp_range_in = 1'b0;
            rsp_cons_in  = '0;
         end
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         signed_mode_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s1_start_ff    <= 1'b0;
         phase_ff       <= dsti_pkg::PH_SKIP;
         neg_ff         <= 1'b0;
         acc_ff         <= '0;
         ovf_ff         <= 1'b0;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         signed_mode_ff <= signed_mode_in;
         s1_valid_ff    <= s1_valid_in;
         s1_start_ff    <= s1_start_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            pos_ff   <= pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ch_ff     <= s1_ch_in;
      rsp_value_ff <= rsp_value_in;
      rsp_range_ff <= rsp_range_in;
      rsp_cons_ff  <= rsp_cons_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.value       = rsp_value_ff;
   assign rsp_ch.range_error = rsp_range_ff;
   assign rsp_ch.consumed    = rsp_cons_ff;

   // checks
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid after reset");

   a_range_has_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_range_ff) |-> rsp_cons_ff != '0)
      else $error("range error without consumed digits");

   a_no_digits_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_cons_ff == '0) |-> (rsp_value_ff == '0 && !rsp_range_ff))
      else $error("nonzero result without digits");

   a_ovf_phase: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (phase_ff == dsti_pkg::PH_DIGITS || phase_ff == dsti_pkg::PH_DONE))
      else $error("overflow flag outside digit phase");

   a_done_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_start_ff && phase_ff == dsti_pkg::PH_DONE) |-> !emit)
      else $error("result after number already finished");

endmodule

`default_nettype wire
